// ===== rtl/frr_pkg.sv =====
// Shared types and constants for the frame region rotator.
// No dependencies; used by the top level and the testbench.
package frr_pkg;

  localparam int PIX_W = 24;
  localparam int CRD_W = 8;
  localparam int DIM_W = 9;

  localparam logic [PIX_W-1:0] PIX_WHITE = 24'hFFFFFF;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_ROTATE = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [1:0] ANG_90  = 2'd0;
  localparam logic [1:0] ANG_180 = 2'd1;
  localparam logic [1:0] ANG_270 = 2'd2;
  localparam logic [1:0] ANG_BAD = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_FIRST = 3'd1;
  localparam logic [2:0] ST_BAD_SEC   = 3'd2;
  localparam logic [2:0] ST_MISORDER  = 3'd3;
  localparam logic [2:0] ST_BAD_ANGLE = 3'd4;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

endpackage

// ===== rtl/frr_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module frr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/frame_region_rotator.sv =====
// Frame region rotator: pixel write, pixel read and region rotate over a frame RAM.
// Write, unused-kind and failed-check items: strobe in the cycle after the accepting
// edge, so such words can follow every cycle. Read: strobe 2 cycles after the edge.
// Rotate: 4 + w*h (copy pass) + cropped w*h (write-back pass) cycles to the strobe; both
// passes move one pixel per cycle. Not ready while busy; next word taken in strobe cycle.
// Reset (rst_n low, synchronous) clears control and sets the dimensions to the maximum;
// RAM contents are left as they are. Results cannot be stalled.
// Depends on frr_pkg and frr_ram.
module frame_region_rotator
  import frr_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_kind,
  input  logic [CRD_W-1:0] in_col,
  input  logic [CRD_W-1:0] in_row,
  input  logic [PIX_W-1:0] in_pixel_in,
  input  logic [CRD_W-1:0] in_left,
  input  logic [CRD_W-1:0] in_top,
  input  logic [CRD_W-1:0] in_right,
  input  logic [CRD_W-1:0] in_bottom,
  input  logic [1:0]       in_angle_code,
  output logic             out_valid,
  output logic [PIX_W-1:0] out_pixel_out,
  output logic [2:0]       out_status,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_SETUP, S_GRAB, S_GAP, S_PUT, S_DRAIN} state_t;

  state_t           state_r;
  logic [DIM_W-1:0] width_r, height_r;
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pixel_r;
  logic [2:0]       out_status_r;
  logic             rd_ok_r;
  logic [CRD_W-1:0] left_r, top_r, right_r, bottom_r;
  logic [1:0]       mode_r;
  logic [DIM_W-1:0] w_r, h_r, amax_r, bmax_r, ca_r, cb_r;
  logic [9:0]       brow_r, bcol_r;
  logic             pend_v_r, pend_put_r, clear_r;
  logic [AW-1:0]    pend_fr_r, pend_sc_r;

  logic             accept;
  logic             pix_in_range;
  logic [2:0]       chk_status;
  logic             fr_we, sc_we;
  logic [AW-1:0]    fr_waddr, fr_raddr, sc_waddr, sc_raddr;
  logic [PIX_W-1:0] fr_wdata, sc_wdata, fr_q, sc_q;
  logic [9:0]       src_r, src_c;
  logic [DIM_W-1:0] cfg_clamped;
  logic [7:0]       wm1, hm1;
  logic signed [10:0] sx, sy;
  logic [9:0]       nx, ny;
  logic [9:0]       room_r, room_c;

  function automatic logic [AW-1:0] pix_addr(input logic [9:0] r, input logic [9:0] c);
    return AW'(32'(r) * MAX_WIDTH + 32'(c));
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_status    = out_status_r;

  // clamp the configuration word to 1..max
  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data == '0) begin
      cfg_clamped = DIM_W'(1);
    end else if (cfg_index == REG_WIDTH && 32'(cfg_data) > MAX_WIDTH) begin
      cfg_clamped = DIM_W'(MAX_WIDTH);
    end else if (cfg_index == REG_HEIGHT && 32'(cfg_data) > MAX_HEIGHT) begin
      cfg_clamped = DIM_W'(MAX_HEIGHT);
    end
  end

  // check the pixel address and the rotate corners
  always_comb begin
    pix_in_range = ({1'b0, in_col} < width_r) && ({1'b0, in_row} < height_r);
    if ({1'b0, in_left} >= width_r || {1'b0, in_top} >= height_r) begin
      chk_status = ST_BAD_FIRST;
    end else if ({1'b0, in_right} >= width_r || {1'b0, in_bottom} >= height_r) begin
      chk_status = ST_BAD_SEC;
    end else if (in_left > in_right || in_top > in_bottom) begin
      chk_status = ST_MISORDER;
    end else if (in_angle_code != ANG_90 && in_angle_code != ANG_180 &&
                 in_angle_code != ANG_270) begin
      chk_status = ST_BAD_ANGLE;
    end else begin
      chk_status = ST_OK;
    end
  end

  // place the rotated copy and crop it to the frame
  always_comb begin
    wm1  = right_r - left_r;
    hm1  = bottom_r - top_r;
    sx   = $signed({3'b0, left_r}) + $signed({4'b0, wm1[7:1]}) - $signed({4'b0, hm1[7:1]});
    sy   = $signed({3'b0, top_r}) + $signed({4'b0, hm1[7:1]}) - $signed({4'b0, wm1[7:1]});
    nx   = sx[10] ? 10'd0 : sx[9:0];
    ny   = sy[10] ? 10'd0 : sy[9:0];
    room_r = (ny < {1'b0, height_r}) ? ({1'b0, height_r} - ny) : 10'd0;
    room_c = (nx < {1'b0, width_r}) ? ({1'b0, width_r} - nx) : 10'd0;
  end

  // source pixel of the write-back pass
  always_comb begin
    case (mode_r)
      ANG_90: begin
        src_r = {1'b0, h_r - 9'd1 - cb_r};
        src_c = {1'b0, ca_r};
      end
      ANG_270: begin
        src_r = {1'b0, cb_r};
        src_c = {1'b0, w_r - 9'd1 - ca_r};
      end
      default: begin
        src_r = {1'b0, h_r - 9'd1 - ca_r};
        src_c = {1'b0, w_r - 9'd1 - cb_r};
      end
    endcase
  end

  // steer the RAM ports
  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = pix_addr({2'b0, in_row}, {2'b0, in_col});
    fr_wdata = in_pixel_in;
    sc_we    = 1'b0;
    sc_waddr = pend_sc_r;
    sc_wdata = fr_q;
    sc_raddr = pix_addr(src_r, src_c);
    if (state_r == S_GRAB) begin
      fr_raddr = pix_addr({2'b0, top_r} + {1'b0, ca_r}, {2'b0, left_r} + {1'b0, cb_r});
    end else begin
      fr_raddr = pix_addr({2'b0, in_row}, {2'b0, in_col});
    end
    if (accept && in_kind == KIND_WRITE && pix_in_range) begin
      fr_we = 1'b1;
    end
    if (pend_v_r) begin
      if (pend_put_r) begin
        fr_we    = 1'b1;
        fr_waddr = pend_fr_r;
        fr_wdata = sc_q;
      end else begin
        sc_we = 1'b1;
        if (clear_r) begin
          fr_we    = 1'b1;
          fr_waddr = pend_fr_r;
          fr_wdata = PIX_WHITE;
        end
      end
    end
  end

  // sequencer, loop counters and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= DIM_W'(MAX_WIDTH > 256 ? 256 : MAX_WIDTH);
      height_r    <= DIM_W'(MAX_HEIGHT > 256 ? 256 : MAX_HEIGHT);
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WIDTH) begin
          width_r <= cfg_clamped;
        end else if (cfg_index == REG_HEIGHT) begin
          height_r <= cfg_clamped;
        end
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_pixel_r  <= '0;
            out_status_r <= ST_OK;
            rd_ok_r      <= pix_in_range;
            left_r       <= in_left;
            top_r        <= in_top;
            right_r      <= in_right;
            bottom_r     <= in_bottom;
            mode_r       <= in_angle_code;
            if (in_kind == KIND_READ) begin
              state_r <= S_READ;
            end else if (in_kind == KIND_ROTATE && chk_status == ST_OK) begin
              state_r <= S_SETUP;
            end else begin
              if (in_kind == KIND_ROTATE) begin
                out_status_r <= chk_status;
              end
              out_valid_r <= 1'b1;
            end
          end
        end
        S_READ: begin
          out_pixel_r <= rd_ok_r ? fr_q : '0;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_SETUP: begin
          w_r     <= {1'b0, wm1} + 9'd1;
          h_r     <= {1'b0, hm1} + 9'd1;
          clear_r <= (mode_r != ANG_180);
          ca_r    <= '0;
          cb_r    <= '0;
          if (mode_r == ANG_180) begin
            amax_r <= {1'b0, hm1} + 9'd1;
            bmax_r <= {1'b0, wm1} + 9'd1;
            brow_r <= {2'b0, top_r};
            bcol_r <= {2'b0, left_r};
          end else begin
            amax_r <= (room_r < {2'b0, wm1} + 10'd1) ? room_r[DIM_W-1:0] : {1'b0, wm1} + 9'd1;
            bmax_r <= (room_c < {2'b0, hm1} + 10'd1) ? room_c[DIM_W-1:0] : {1'b0, hm1} + 9'd1;
            brow_r <= ny;
            bcol_r <= nx;
          end
          state_r <= S_GRAB;
        end
        S_GRAB: begin
          // copy one pixel to scratch; write lands next cycle
          pend_v_r   <= 1'b1;
          pend_put_r <= 1'b0;
          pend_fr_r  <= fr_raddr;
          pend_sc_r  <= pix_addr({1'b0, ca_r}, {1'b0, cb_r});
          if (cb_r == w_r - 9'd1) begin
            cb_r <= '0;
            if (ca_r == h_r - 9'd1) begin
              ca_r    <= '0;
              state_r <= S_GAP;
            end else begin
              ca_r <= ca_r + 9'd1;
            end
          end else begin
            cb_r <= cb_r + 9'd1;
          end
        end
        S_GAP: begin
          // let the last scratch write settle
          state_r <= (amax_r == '0 || bmax_r == '0) ? S_DRAIN : S_PUT;
        end
        S_PUT: begin
          pend_v_r   <= 1'b1;
          pend_put_r <= 1'b1;
          pend_fr_r  <= pix_addr(brow_r + {1'b0, ca_r}, bcol_r + {1'b0, cb_r});
          if (cb_r == bmax_r - 9'd1) begin
            cb_r <= '0;
            if (ca_r == amax_r - 9'd1) begin
              state_r <= S_DRAIN;
            end else begin
              ca_r <= ca_r + 9'd1;
            end
          end else begin
            cb_r <= cb_r + 9'd1;
          end
        end
        S_DRAIN: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  frr_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_frame (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (fr_raddr),
    .rdata (fr_q)
  );

  frr_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_scratch (
    .clk   (clk),
    .we    (sc_we),
    .waddr (sc_waddr),
    .wdata (sc_wdata),
    .raddr (sc_raddr),
    .rdata (sc_q)
  );

endmodule

// ===== sim/frame_region_rotator_tb.sv =====
// Testbench for frame_region_rotator: pixel writes, reads and region rotates
// checked against a behavioral frame model. Depends on frr_pkg and the RTL.
`timescale 1ns / 100ps

module frame_region_rotator_tb;
  import frr_pkg::*;

  localparam int FRAME_DIM   = 256;
  localparam int FILL_COLS   = 8;
  localparam int FILL_ROWS   = 6;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [2:0]       status;
  } result_word_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       in_kind;
  logic [CRD_W-1:0] in_col, in_row, in_left, in_top, in_right, in_bottom;
  logic [PIX_W-1:0] in_pixel_in;
  logic [1:0]       in_angle_code;
  logic             out_valid;
  logic [PIX_W-1:0] out_pixel_out;
  logic [2:0]       out_status;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [DIM_W-1:0] cfg_data;

  logic [PIX_W-1:0] frame_mdl [FRAME_DIM*FRAME_DIM];
  logic [PIX_W-1:0] scratch_mdl [FRAME_DIM*FRAME_DIM];
  int               width_mdl, height_mdl;
  result_word_t     pending_results [$];
  int               fail_count, result_count, item_count, cycle_count;
  int               gap_pct;

  frame_region_rotator dut (
    .clk, .rst_n, .start, .busy, .in_kind, .in_col, .in_row, .in_pixel_in,
    .in_left, .in_top, .in_right, .in_bottom, .in_angle_code,
    .out_valid, .out_pixel_out, .out_status,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Compare each strobed word with the oldest pending prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      result_count++;
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected word pixel=%h status=%0d", $time, out_pixel_out, out_status);
      end else begin
        if (out_pixel_out !== pending_results[0].pixel) begin
          fail_count++;
          $display("%0t: pixel expected %h actual %h", $time,
                   pending_results[0].pixel, out_pixel_out);
        end
        if (out_status !== pending_results[0].status) begin
          fail_count++;
          $display("%0t: status expected %0d actual %0d", $time,
                   pending_results[0].status, out_status);
        end
        void'(pending_results.pop_front());
      end
    end
  end

  function automatic int clamp_dim(int v);
    if (v < 1) return 1;
    if (v > FRAME_DIM) return FRAME_DIM;
    return v;
  endfunction

  // Copy the region to scratch, optionally clearing it to white
  function automatic void grab_region(int l, int t, int w, int h, bit clear);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        scratch_mdl[r*FRAME_DIM + c] = frame_mdl[(t+r)*FRAME_DIM + l + c];
        if (clear) frame_mdl[(t+r)*FRAME_DIM + l + c] = PIX_WHITE;
      end
  endfunction

  function automatic void turn_quarter(int l, int t, int rt, int b, bit clockwise);
    int w, h, sx, sy, src;
    w  = rt - l + 1;
    h  = b - t + 1;
    sx = l + (rt - l) / 2 - (b - t) / 2;
    sy = t + (b - t) / 2 - (rt - l) / 2;
    if (sx < 0) sx = 0;
    if (sy < 0) sy = 0;
    grab_region(l, t, w, h, 1'b1);
    for (int i = 0; i < w && i + sy < height_mdl; i++)
      for (int j = 0; j < h && j + sx < width_mdl; j++) begin
        src = clockwise ? (h-1-j)*FRAME_DIM + i : j*FRAME_DIM + (w-1-i);
        frame_mdl[(sy+i)*FRAME_DIM + sx + j] = scratch_mdl[src];
      end
  endfunction

  function automatic void turn_half(int l, int t, int rt, int b);
    int w, h;
    w = rt - l + 1;
    h = b - t + 1;
    grab_region(l, t, w, h, 1'b0);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        frame_mdl[(t+r)*FRAME_DIM + l + c] = scratch_mdl[(h-1-r)*FRAME_DIM + w-1-c];
  endfunction

  // Apply one accepted item to the frame model and return its result word
  function automatic result_word_t frame_result(logic [1:0] kind, int col, int row,
      logic [PIX_W-1:0] pix, int l, int t, int rt, int b, logic [1:0] ang);
    result_word_t res;
    res = '{pixel: '0, status: ST_OK};
    if (kind == KIND_WRITE) begin
      if (col < width_mdl && row < height_mdl) frame_mdl[row*FRAME_DIM + col] = pix;
    end else if (kind == KIND_READ) begin
      if (col < width_mdl && row < height_mdl) res.pixel = frame_mdl[row*FRAME_DIM + col];
    end else if (kind == KIND_ROTATE) begin
      if (l >= width_mdl || t >= height_mdl) res.status = ST_BAD_FIRST;
      else if (rt >= width_mdl || b >= height_mdl) res.status = ST_BAD_SEC;
      else if (l > rt || t > b) res.status = ST_MISORDER;
      else if (ang == ANG_90) turn_quarter(l, t, rt, b, 1'b1);
      else if (ang == ANG_180) turn_half(l, t, rt, b);
      else if (ang == ANG_270) turn_quarter(l, t, rt, b, 1'b0);
      else res.status = ST_BAD_ANGLE;
    end
    return res;
  endfunction

  // Present one word, hold it until accepted, then maybe idle
  task automatic send_item(logic [1:0] kind, int col, int row, int pix, int l, int t,
      int rt, int b, logic [1:0] ang);
    logic [CRD_W-1:0] col_w, row_w, l_w, t_w, rt_w, b_w;
    logic [PIX_W-1:0] pix_w;
    int gap;
    col_w = CRD_W'(col);
    row_w = CRD_W'(row);
    l_w   = CRD_W'(l);
    t_w   = CRD_W'(t);
    rt_w  = CRD_W'(rt);
    b_w   = CRD_W'(b);
    pix_w = PIX_W'(pix);
    start         <= 1'b1;
    in_kind       <= kind;
    in_col        <= col_w;
    in_row        <= row_w;
    in_pixel_in   <= pix_w;
    in_left       <= l_w;
    in_top        <= t_w;
    in_right      <= rt_w;
    in_bottom     <= b_w;
    in_angle_code <= ang;
    do @(posedge clk); while (busy);
    pending_results.push_back(frame_result(kind, int'(col_w), int'(row_w), pix_w,
                                           int'(l_w), int'(t_w), int'(rt_w), int'(b_w),
                                           ang));
    item_count++;
    gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write one dimension register while the block is idle
  task automatic write_dim(logic [1:0] idx, logic [DIM_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_WIDTH) width_mdl = clamp_dim(int'(val));
    else height_mdl = clamp_dim(int'(val));
  endtask

  task automatic rand_rotate(int span);
    int l, t;
    l = $urandom_range(width_mdl - 1);
    t = $urandom_range(height_mdl - 1);
    send_item(KIND_ROTATE, $urandom, $urandom, $urandom, l, t,
              l + $urandom_range(span), t + $urandom_range(span),
              2'($urandom_range(2)));
  endtask

  // Define every pixel of the working frame, then shrink the frame to it
  task automatic test_fill_frame;
    gap_pct = 0;
    for (int r = 0; r < FILL_ROWS; r++)
      for (int c = 0; c < FILL_COLS; c++)
        send_item(KIND_WRITE, c, r, $urandom, $urandom, $urandom, $urandom, $urandom,
                  2'($urandom));
    write_dim(REG_WIDTH, DIM_W'(FILL_COLS));
    write_dim(REG_HEIGHT, DIM_W'(FILL_ROWS));
  endtask

  task automatic test_directed;
    gap_pct = 0;
    send_item(KIND_READ, 7, 5, 0, 0, 0, 0, 0, ANG_90);
    send_item(KIND_WRITE, 0, 0, 'hFFFFFF, 0, 0, 0, 0, ANG_90);
    send_item(KIND_WRITE, 8, 0, 'h123456, 0, 0, 0, 0, ANG_90);
    send_item(KIND_READ, 8, 0, 0, 0, 0, 0, 0, ANG_90);
    send_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, ANG_90);
    send_item(KIND_NONE, 3, 2, 'h123456, 1, 2, 3, 4, ANG_90);
    // corner and angle errors
    send_item(KIND_ROTATE, 0, 0, 0, 8, 0, 8, 0, ANG_90);
    send_item(KIND_ROTATE, 0, 0, 0, 1, 1, 7, 6, ANG_90);
    send_item(KIND_ROTATE, 0, 0, 0, 5, 1, 3, 4, ANG_90);
    send_item(KIND_ROTATE, 0, 0, 0, 1, 1, 3, 3, ANG_BAD);
    // small rotates, odd height with even width for the half turn
    send_item(KIND_ROTATE, 0, 0, 0, 2, 1, 5, 3, ANG_180);
    send_item(KIND_ROTATE, 0, 0, 0, 0, 1, 5, 2, ANG_90);
    send_item(KIND_ROTATE, 0, 0, 0, 4, 3, 7, 5, ANG_270);
    // whole frame
    send_item(KIND_ROTATE, 0, 0, 0, 0, 0, 7, 5, ANG_180);
    send_item(KIND_ROTATE, 0, 0, 0, 0, 0, 7, 5, ANG_270);
    send_item(KIND_READ, 1, 3, 0, 0, 0, 0, 0, ANG_90);
    send_item(KIND_READ, 6, 5, 0, 0, 0, 0, 0, ANG_90);
  endtask

  // Clamped dimensions, then a shrunken frame with cropped rotates
  task automatic test_small_frame;
    write_dim(REG_WIDTH, 9'd0);
    write_dim(REG_HEIGHT, 9'd300);
    gap_pct = 33;
    send_item(KIND_WRITE, 0, 0, 'hA5A5A5, 0, 0, 0, 0, ANG_90);
    send_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, ANG_90);
    send_item(KIND_ROTATE, 0, 0, 0, 0, 0, 0, 0, ANG_90);
    send_item(KIND_ROTATE, 0, 0, 0, 1, 0, 1, 0, ANG_90);
    write_dim(REG_WIDTH, 9'd5);
    write_dim(REG_HEIGHT, 9'd4);
    for (int k = 0; k < 10; k++) begin
      if (k % 3 == 0) rand_rotate(4);
      else send_item(2'($urandom_range(3)), $urandom_range(9), $urandom_range(7), $urandom,
                     $urandom, $urandom, $urandom, $urandom, 2'($urandom));
    end
    write_dim(REG_WIDTH, DIM_W'(FILL_COLS));
    write_dim(REG_HEIGHT, DIM_W'(FILL_ROWS));
  endtask

  // Random traffic across idle phases
  task automatic test_random;
    int phase_pct [4] = '{0, 83, 0, 33};
    for (int p = 0; p < 4; p++) begin
      gap_pct = phase_pct[p];
      for (int k = 0; k < 6; k++) begin
        case ($urandom_range(9))
          0, 1, 2: send_item(KIND_WRITE, $urandom_range(9), $urandom_range(7), $urandom,
                             $urandom, $urandom, $urandom, $urandom, 2'($urandom));
          3, 4, 5: send_item(KIND_READ, $urandom_range(9), $urandom_range(7), $urandom,
                             $urandom, $urandom, $urandom, $urandom, 2'($urandom));
          6, 7: rand_rotate(6);
          8: send_item(KIND_ROTATE, $urandom, $urandom, $urandom, $urandom_range(9),
                       $urandom_range(7), $urandom_range(9), $urandom_range(7),
                       2'($urandom));
          default: send_item(KIND_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, 2'($urandom));
        endcase
        if (k == 3 && p == 1) drain();
      end
    end
  endtask

  initial begin
    fail_count = 0; result_count = 0; item_count = 0; cycle_count = 0; gap_pct = 0;
    width_mdl = FRAME_DIM; height_mdl = FRAME_DIM;
    rst_n = 1'b0; start = 1'b0; in_kind = '0; in_col = '0; in_row = '0;
    in_pixel_in = '0; in_left = '0; in_top = '0; in_right = '0; in_bottom = '0;
    in_angle_code = '0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_frame();
    test_directed();
    test_small_frame();
    test_random();
    drain();
    $display("Ran %0d items with %0d result words: fill, corner errors, all angles,",
             item_count, result_count);
    $display("whole-frame and cropped rotates, clamped and shrunken frames, idle phases.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/frr_pkg.sv
rtl/frr_ram.sv
rtl/frame_region_rotator.sv
sim/frame_region_rotator_tb.sv
